// File: rtl/core/rsmp_pkg.sv
// Shared types and constants for the polyline resampler.
package rsmp_pkg;

  localparam int COORD_W   = 32;
  localparam int DELTA_W   = 33;          // |dx|, |dy| below 2^32
  localparam int SPACE_W   = 31;
  localparam int SQ_W      = 66;          // dx^2 + dy^2
  localparam int ROOT_W    = 68;          // sqrt working width
  localparam int DIST_W    = 34;
  localparam int PROD_W    = 64;          // spacing * |d|
  localparam int NUM_W     = 67;          // k*s*|d| + dist/2
  localparam int QUO_W     = 33;
  localparam int REACH_W   = 36;
  localparam int CNT_W     = 6;

  localparam logic [CNT_W-1:0] MUL_STEPS  = 6'd33;
  localparam logic [CNT_W-1:0] SQRT_STEPS = 6'd34;
  localparam logic [CNT_W-1:0] DIV_STEPS  = 6'd33;

  localparam logic [SPACE_W-1:0] SPACING_RESET = 31'd65536;

  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [DELTA_W-1:0] ax;
    logic [DELTA_W-1:0] ay;
    logic               negx;
    logic               negy;
  } seg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SQRT,
    B_PREP,
    B_EMIT,
    B_DIV,
    B_PLACE
  } back_state_t;

endpackage

// File: rtl/core/rsmp_ifs.sv
// Channel interfaces: waypoints in, points out, spacing register write.
interface rsmp_way_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] way_x;
  logic signed [31:0] way_y;
  logic               path_start;
  modport source (output valid, way_x, way_y, path_start, input ready);
  modport sink (input valid, way_x, way_y, path_start, output ready);
endinterface

interface rsmp_pt_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               run_last;
  modport source (output valid, point_x, point_y, run_last, input ready);
  modport sink (input valid, point_x, point_y, run_last, output ready);
endinterface

interface rsmp_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] point_spacing;
  modport source (output valid, point_spacing, input ready);
  modport sink (input valid, point_spacing, output ready);
endinterface

// File: rtl/core/rsmp_front.sv
// Front end: takes waypoints, keeps the previous one, queues segments.
module rsmp_front
  import rsmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rsmp_way_if.sink    way,
  input  logic        q_full,
  output logic        q_push,
  output seg_t        q_data
);

  logic [COORD_W-1:0] prev_x;
  logic [COORD_W-1:0] prev_y;
  logic               have_prev;
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic               xfer;

  assign way.ready = !q_full;
  assign xfer      = way.valid && way.ready;

  assign dx = DELTA_W'(way.way_x) - DELTA_W'($signed(prev_x));
  assign dy = DELTA_W'(way.way_y) - DELTA_W'($signed(prev_y));

  assign q_push      = xfer && !way.path_start && have_prev;
  assign q_data.px   = prev_x;
  assign q_data.py   = prev_y;
  assign q_data.negx = dx[DELTA_W-1];
  assign q_data.negy = dy[DELTA_W-1];
  assign q_data.ax   = dx[DELTA_W-1] ? DELTA_W'(-dx) : DELTA_W'(dx);
  assign q_data.ay   = dy[DELTA_W-1] ? DELTA_W'(-dy) : DELTA_W'(dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x    <= '0;
      prev_y    <= '0;
      have_prev <= 1'b0;
    end else if (xfer) begin
      prev_x    <= way.way_x;
      prev_y    <= way.way_y;
      have_prev <= 1'b1;
    end
  end

endmodule

// File: rtl/core/rsmp_queue.sv
// Two-entry segment queue between front and back.
module rsmp_queue
  import rsmp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  seg_t  wr_data,
  input  logic  pop,
  output seg_t  rd_data,
  output logic  full,
  output logic  empty
);

  seg_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: rtl/core/rsmp_back.sv
// Back end: segment length, step count and point placement, one point at a time.
module rsmp_back
  import rsmp_pkg::*;
#(
  parameter int MAX_POINTS_PER_SEGMENT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [SPACE_W-1:0] spacing,
  input  logic               q_empty,
  input  seg_t               q_data,
  output logic               q_pop,
  rsmp_pt_if.source          pts
);

  localparam int KW = $clog2(MAX_POINTS_PER_SEGMENT + 2) + 1;

  back_state_t state, state_next;

  logic [CNT_W-1:0]   cnt;
  logic [COORD_W-1:0] px, py, pend_x, pend_y;
  logic               negx, negy;
  logic [SQ_W-1:0]    mcx, mcy, d2;
  logic [DELTA_W-1:0] mbx, mby;
  logic [SPACE_W-1:0] sb;
  logic [PROD_W-1:0]  smx, smy;
  logic [ROOT_W-1:0]  op, res, one;
  logic [DIST_W-1:0]  seg_len;
  logic [NUM_W-1:0]   numx, numy;
  logic [QUO_W-1:0]   nshx, nshy, qx, qy;
  logic [DIST_W-1:0]  remx, remy;
  logic [REACH_W-1:0] reach;
  logic [KW-1:0]      k;
  logic               out_valid, out_last;
  logic [COORD_W-1:0] out_x, out_y;

  logic [SPACE_W-1:0] s_eff;
  logic               out_free, cont, step_done, sq_ge, gex, gey, iterating;
  logic [ROOT_W-1:0]  sq_trial;
  logic [DIST_W:0]    shx, shy;

  assign s_eff     = (spacing == '0) ? SPACE_W'(1) : spacing;
  assign out_free  = !out_valid || pts.ready;
  assign cont      = (reach <= REACH_W'(seg_len)) &&
                     ((k + KW'(2)) <= KW'(MAX_POINTS_PER_SEGMENT));
  assign sq_trial  = res + one;
  assign sq_ge     = op >= sq_trial;
  assign shx       = {remx, nshx[QUO_W-1]};
  assign shy       = {remy, nshy[QUO_W-1]};
  assign gex       = shx >= (DIST_W+1)'(seg_len);
  assign gey       = shy >= (DIST_W+1)'(seg_len);
  assign q_pop     = (state == B_IDLE) && !q_empty;
  assign iterating = (state == B_MUL) || (state == B_SQRT) || (state == B_DIV);

  assign pts.valid    = out_valid;
  assign pts.point_x  = out_x;
  assign pts.point_y  = out_y;
  assign pts.run_last = out_last;

  always_comb begin
    state_next = state;
    step_done  = 1'b0;
    case (state)
      B_IDLE:  if (!q_empty) state_next = B_MUL;
      B_MUL: begin
        step_done = (cnt == MUL_STEPS - 1'b1);
        if (step_done) state_next = B_SQRT;
      end
      B_SQRT: begin
        step_done = (cnt == SQRT_STEPS - 1'b1);
        if (step_done) state_next = B_PREP;
      end
      B_PREP:  state_next = B_EMIT;
      B_EMIT:  if (out_free) state_next = cont ? B_DIV : B_IDLE;
      B_DIV: begin
        step_done = (cnt == DIV_STEPS - 1'b1);
        if (step_done) state_next = B_PLACE;
      end
      B_PLACE: state_next = B_EMIT;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // iteration counter, runs only in the iterative phases
  always_ff @(posedge clk) begin
    if (rst || step_done || !iterating) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == B_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (pts.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_EMIT && out_free) begin
      out_x    <= pend_x;
      out_y    <= pend_y;
      out_last <= !cont;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        px   <= q_data.px;
        py   <= q_data.py;
        negx <= q_data.negx;
        negy <= q_data.negy;
        mcx  <= SQ_W'(q_data.ax);
        mcy  <= SQ_W'(q_data.ay);
        mbx  <= q_data.ax;
        mby  <= q_data.ay;
        sb   <= s_eff;
        d2   <= '0;
        smx  <= '0;
        smy  <= '0;
      end
      // shift-add: ax*ax + ay*ay and s*ax, s*ay together
      B_MUL: begin
        d2  <= d2 + (mbx[0] ? mcx : '0) + (mby[0] ? mcy : '0);
        smx <= smx + (sb[0] ? PROD_W'(mcx) : '0);
        smy <= smy + (sb[0] ? PROD_W'(mcy) : '0);
        mcx <= mcx << 1;
        mcy <= mcy << 1;
        mbx <= mbx >> 1;
        mby <= mby >> 1;
        sb  <= sb >> 1;
        if (cnt == MUL_STEPS - 1'b1) begin
          op  <= '0;
          res <= '0;
          one <= ROOT_W'(1) << (SQ_W);
        end
      end
      B_SQRT: begin
        if (cnt == '0) begin
          // first step works on the finished square sum
          if (ROOT_W'(d2) >= one) begin
            op  <= ROOT_W'(d2) - one;
            res <= one;
          end else begin
            op  <= ROOT_W'(d2);
            res <= '0;
          end
        end else if (sq_ge) begin
          op  <= op - sq_trial;
          res <= (res >> 1) + one;
        end else begin
          res <= res >> 1;
        end
        one <= one >> 2;
      end
      B_PREP: begin
        seg_len <= DIST_W'(res);
        numx    <= NUM_W'(smx) + NUM_W'(res[DIST_W-1:1]);
        numy    <= NUM_W'(smy) + NUM_W'(res[DIST_W-1:1]);
        reach   <= REACH_W'({s_eff, 1'b0});
        k       <= '0;
        pend_x  <= px;
        pend_y  <= py;
      end
      B_EMIT: begin
        if (out_free && cont) begin
          k     <= k + 1'b1;
          reach <= reach + REACH_W'(s_eff);
          remx  <= numx[NUM_W-1:QUO_W];
          remy  <= numy[NUM_W-1:QUO_W];
          nshx  <= numx[QUO_W-1:0];
          nshy  <= numy[QUO_W-1:0];
          qx    <= '0;
          qy    <= '0;
        end
      end
      // restoring division, one quotient bit per cycle for x and y
      B_DIV: begin
        remx <= gex ? DIST_W'(shx - (DIST_W+1)'(seg_len)) : shx[DIST_W-1:0];
        remy <= gey ? DIST_W'(shy - (DIST_W+1)'(seg_len)) : shy[DIST_W-1:0];
        qx   <= {qx[QUO_W-2:0], gex};
        qy   <= {qy[QUO_W-2:0], gey};
        nshx <= nshx << 1;
        nshy <= nshy << 1;
      end
      B_PLACE: begin
        pend_x <= negx ? px - qx[COORD_W-1:0] : px + qx[COORD_W-1:0];
        pend_y <= negy ? py - qy[COORD_W-1:0] : py + qy[COORD_W-1:0];
        numx   <= numx + NUM_W'(smx);
        numy   <= numy + NUM_W'(smy);
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/polyline_fixed_spacing_resampler.sv
// Top level of the fixed-spacing polyline resampler.
//
// Channels: way (waypoint in), pts (resampled points out), cfg (spacing
// register write, always ready, write only while idle). Each transfer
// happens when valid and ready are both high.
// The first waypoint of a path is stored and gives no point. Each later
// waypoint queues a segment from the stored one; the back end emits the
// stored waypoint, then points one spacing apart toward the new waypoint,
// run_last marking the last. The new waypoint itself is never emitted.
// After a segment transfer the back end runs a shift-add multiply and a
// square root before its first point, then a restoring divide for each
// further point.
// A two-entry segment queue lets waypoints transfer while the back end works;
// way.ready drops only when that queue is full.
// When pts is stalled the back end holds its output register and waits.
// Reset (rst, synchronous) clears the stored waypoint, the queue and the
// output, and sets the spacing to 65536 coordinate units.
module polyline_fixed_spacing_resampler
  import rsmp_pkg::*;
#(
  parameter int MAX_POINTS_PER_SEGMENT = 64
) (
  input  logic       clk,
  input  logic       rst,
  rsmp_way_if.sink   way,
  rsmp_pt_if.source  pts,
  rsmp_cfg_if.sink   cfg
);

  logic [SPACE_W-1:0] spacing;
  seg_t  q_wdata, q_rdata;
  logic  q_push, q_full;
  logic  q_pop, q_empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= SPACING_RESET;
    end else if (cfg.valid) begin
      spacing <= cfg.point_spacing;
    end
  end

  rsmp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .way    (way),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  rsmp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wdata),
    .pop     (q_pop),
    .rd_data (q_rdata),
    .full    (q_full),
    .empty   (q_empty)
  );

  rsmp_back #(
    .MAX_POINTS_PER_SEGMENT (MAX_POINTS_PER_SEGMENT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .spacing (spacing),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .pts     (pts)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("segment queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("segment queue underflow");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !pts.valid)
    else $error("point valid right after reset");

endmodule
